// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the calibration block checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, held off while rst is high.
`define AAC_ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("aac assertion failed");

// Check a property on every rising edge of clk, reset included.
`define AAC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("aac assertion failed");

`endif

// File: hw/rtl/aac_pkg.sv
// ---------------------------------------------------------------------------
// aac_pkg
// Types and constants of the accelerometer affine calibration block.
// ---------------------------------------------------------------------------
`default_nettype none

package aac_pkg;

  localparam int RAW_W     = 16;  // raw sample
  localparam int BIAS_W    = 20;  // Q16.4 bias
  localparam int D_W       = 21;  // bias-removed sample, Q.4
  localparam int FAC_W     = 16;  // Q2.14 factor
  localparam int ROW_W     = 3 * FAC_W;
  localparam int PROD_W    = FAC_W + D_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int FRAC_BITS = 14;
  localparam int RND_W     = SUM_W - FRAC_BITS;
  localparam int OUT_W     = 24;
  localparam int ADDR_W    = 6;
  localparam int DATA_W    = 64;

  localparam logic [ROW_W-1:0] ROW_X_RST = 48'h0000_0000_4000;
  localparam logic [ROW_W-1:0] ROW_Y_RST = 48'h0000_4000_0000;
  localparam logic [ROW_W-1:0] ROW_Z_RST = 48'h4000_0000_0000;

  typedef enum logic [2:0] {
    REG_ROW_X  = 3'd0,
    REG_ROW_Y  = 3'd1,
    REG_ROW_Z  = 3'd2,
    REG_BIAS_X = 3'd3,
    REG_BIAS_Y = 3'd4,
    REG_BIAS_Z = 3'd5
  } aac_reg_idx_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
  } aac_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] cal_x;
    logic signed [OUT_W-1:0] cal_y;
    logic signed [OUT_W-1:0] cal_z;
  } aac_out_t;

  typedef struct packed {
    logic signed [D_W-1:0] dx;
    logic signed [D_W-1:0] dy;
    logic signed [D_W-1:0] dz;
  } aac_dvec_t;

  typedef struct packed {
    logic [ROW_W-1:0]         row_x;
    logic [ROW_W-1:0]         row_y;
    logic [ROW_W-1:0]         row_z;
    logic signed [BIAS_W-1:0] bias_x;
    logic signed [BIAS_W-1:0] bias_y;
    logic signed [BIAS_W-1:0] bias_z;
  } aac_cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/aac_regs.sv
// ---------------------------------------------------------------------------
// aac_regs
// APB register file holding the correction matrix rows and axis biases.
// ---------------------------------------------------------------------------
`default_nettype none

module aac_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [aac_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [aac_pkg::DATA_W-1:0]   pwdata,
  output logic      [aac_pkg::DATA_W-1:0]   prdata,
  output aac_pkg::aac_cfg_t                 cfg
);
  import aac_pkg::*;

  aac_reg_idx_t idx;
  logic         wr;

  // registers sit on 8-byte boundaries
  assign idx = aac_reg_idx_t'(paddr[ADDR_W-1:3]);
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_x  <= ROW_X_RST;
      cfg.row_y  <= ROW_Y_RST;
      cfg.row_z  <= ROW_Z_RST;
      cfg.bias_x <= '0;
      cfg.bias_y <= '0;
      cfg.bias_z <= '0;
    end else if (wr) begin
      case (idx)
        REG_ROW_X:  cfg.row_x  <= pwdata[ROW_W-1:0];
        REG_ROW_Y:  cfg.row_y  <= pwdata[ROW_W-1:0];
        REG_ROW_Z:  cfg.row_z  <= pwdata[ROW_W-1:0];
        REG_BIAS_X: cfg.bias_x <= pwdata[BIAS_W-1:0];
        REG_BIAS_Y: cfg.bias_y <= pwdata[BIAS_W-1:0];
        REG_BIAS_Z: cfg.bias_z <= pwdata[BIAS_W-1:0];
        default: ;  // unmapped slots ignore writes
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROW_X:  prdata = DATA_W'(cfg.row_x);
      REG_ROW_Y:  prdata = DATA_W'(cfg.row_y);
      REG_ROW_Z:  prdata = DATA_W'(cfg.row_z);
      REG_BIAS_X: prdata = DATA_W'(unsigned'(cfg.bias_x));
      REG_BIAS_Y: prdata = DATA_W'(unsigned'(cfg.bias_y));
      REG_BIAS_Z: prdata = DATA_W'(unsigned'(cfg.bias_z));
      default:    prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/aac_bias.sv
// ---------------------------------------------------------------------------
// aac_bias
// Stage 1: scale raw samples to Q.4 and remove the per-axis bias.
// ---------------------------------------------------------------------------
`default_nettype none

module aac_bias (
  input  wire logic                 clk,
  input  wire aac_pkg::aac_in_t     sample,
  input  wire aac_pkg::aac_cfg_t    cfg,
  output aac_pkg::aac_dvec_t        dvec
);
  import aac_pkg::*;

  function automatic logic signed [D_W-1:0] debias(
    input logic signed [RAW_W-1:0]  raw,
    input logic signed [BIAS_W-1:0] bias
  );
    logic signed [D_W-1:0] scaled;
    scaled = $signed({raw[RAW_W-1], raw, 4'b0000});
    return scaled - D_W'(bias);
  endfunction

  always_ff @(posedge clk) begin
    dvec.dx <= debias(sample.raw_x, cfg.bias_x);
    dvec.dy <= debias(sample.raw_y, cfg.bias_y);
    dvec.dz <= debias(sample.raw_z, cfg.bias_z);
  end

endmodule

`default_nettype wire

// File: hw/rtl/aac_row.sv
// ---------------------------------------------------------------------------
// aac_row
// Stages 2-4 for one output axis: multiply, sum, round and saturate.
// ---------------------------------------------------------------------------
`default_nettype none

module aac_row (
  input  wire logic                          clk,
  input  wire aac_pkg::aac_dvec_t            dvec,
  input  wire logic [aac_pkg::ROW_W-1:0]     factors,
  output logic signed [aac_pkg::OUT_W-1:0]   cal
);
  import aac_pkg::*;

  logic signed [FAC_W-1:0]  f0, f1, f2;
  logic signed [PROD_W-1:0] p0, p1, p2;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  lifted;
  logic signed [RND_W-1:0]  rnd;
  logic signed [OUT_W-1:0]  cal_next;

  assign f0 = $signed(factors[FAC_W-1:0]);
  assign f1 = $signed(factors[2*FAC_W-1:FAC_W]);
  assign f2 = $signed(factors[3*FAC_W-1:2*FAC_W]);

  // stage 2: three products
  always_ff @(posedge clk) begin
    p0 <= f0 * dvec.dx;
    p1 <= f1 * dvec.dy;
    p2 <= f2 * dvec.dz;
  end

  // stage 3: sum, cannot overflow (|sum| < 2^37)
  always_ff @(posedge clk) begin
    sum <= SUM_W'(p0) + SUM_W'(p1) + SUM_W'(p2);
  end

  // stage 4: round half up, drop fraction, clamp to 24 bits
  assign lifted = sum + SUM_W'(1 << (FRAC_BITS - 1));
  assign rnd    = lifted[SUM_W-1:FRAC_BITS];

  always_comb begin
    if (rnd[RND_W-1] != rnd[OUT_W-1]) begin
      cal_next = rnd[RND_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      cal_next = rnd[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    cal <= cal_next;
  end

endmodule

`default_nettype wire

// File: hw/rtl/accel_affine_calibration.sv
// ---------------------------------------------------------------------------
// accel_affine_calibration
// Three-axis accelerometer affine calibration: bias removal, 3x3 Q2.14
// matrix multiply, rounding and 24-bit saturation.
// ---------------------------------------------------------------------------
//  channel   | signals                              | handshake
//  ----------+--------------------------------------+------------------------
//  sample in | start, busy, sample{raw_x,y,z}       | start & !busy
//  result    | done, result{cal_x,y,z}              | done, one cycle
//  config    | psel penable pwrite paddr pwdata ... | psel&penable&pwrite
//
//  Four-stage pipeline: debias, multiply, sum, round/saturate.
//  An accepted sample passes through the dvec, product, sum and cal registers
//  before its word appears with done; a new sample is taken every cycle.
//  busy stays low: the receiver cannot stall, so nothing ever backs up.
//  rst (synchronous) clears the valid bits and loads identity/zero cal.
// ---------------------------------------------------------------------------
`default_nettype none

module accel_affine_calibration (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // sample channel
  input  wire logic                        start,
  output logic                             busy,
  input  wire aac_pkg::aac_in_t            sample,
  // result channel
  output logic                             done,
  output aac_pkg::aac_out_t                result,
  // APB configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [aac_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [aac_pkg::DATA_W-1:0]  pwdata,
  output logic      [aac_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);
  import aac_pkg::*;

  aac_cfg_t  cfg;
  aac_dvec_t dvec;

  // valid bits riding along with the debias, product and sum stages
  logic v_dvec;
  logic v_prod;
  logic v_sum;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  aac_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  aac_bias u_bias (
    .clk    (clk),
    .sample (sample),
    .cfg    (cfg),
    .dvec   (dvec)
  );

  // one multiply/sum/round lane per output axis
  aac_row u_row_x (
    .clk     (clk),
    .dvec    (dvec),
    .factors (cfg.row_x),
    .cal     (result.cal_x)
  );

  aac_row u_row_y (
    .clk     (clk),
    .dvec    (dvec),
    .factors (cfg.row_y),
    .cal     (result.cal_y)
  );

  aac_row u_row_z (
    .clk     (clk),
    .dvec    (dvec),
    .factors (cfg.row_z),
    .cal     (result.cal_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v_dvec <= 1'b0;
      v_prod <= 1'b0;
      v_sum  <= 1'b0;
      done   <= 1'b0;
    end else begin
      v_dvec <= start & ~busy;
      v_prod <= v_dvec;
      v_sum  <= v_prod;
      done   <= v_sum;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/aac_checker.sv
// ---------------------------------------------------------------------------
// aac_checker
// Port-level checks on the calibration block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module aac_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire logic pready
);

  // every accepted sample yields a word on done once it has passed the dvec, product, sum and cal registers
  `AAC_ASSERT_CLK(a_latency, clk, rst, (start && !busy) |-> ##4 done)
  // no word appears on done without an accepted sample having passed through those registers
  `AAC_ASSERT_CLK(a_no_spurious, clk, rst, done |-> $past(start && !busy, 4))
  // reset empties the pipeline
  `AAC_ASSERT_ALWAYS(a_rst_flush, clk, rst |=> !done)
  // config port and sample port never back-pressure
  `AAC_ASSERT_CLK(a_always_ready, clk, rst, pready && !busy)

endmodule

bind accel_affine_calibration aac_checker u_aac_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .pready (pready)
);

`default_nettype wire
